FILE: hw/rtl/kdcq_pkg.sv
`default_nettype none
package kdcq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_LEVEL   = 6;

  localparam int HANDLE_W = 32;
  localparam int STEP_W   = 6;
  localparam int OP_W     = 2;

  localparam logic [STEP_W-1:0] LEVEL_STEP_RESET = 6'd5;

  // operation codes; code 3 is unused and ignored
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_POP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic push_in;    // store the incoming word at the write pointer
    logic half_adv;   // overflow: jump read pointer half a ring, hold payload
    logic walk_step;  // advance read pointer one entry
    logic push_held;  // store the held word at the write pointer
    logic clear_ptrs; // clear both pointers, mark empty
    logic pop_empty;  // emit the empty result
    logic pop_start;  // latch backlog, clear burst counters
    logic pop_emit;   // emit one entry of the burst
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic walk_done;
    logic burst_more;
  } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/keyframe_drop_catchup_queue_core.sv
// Channel   Handshake                  Payload
// input     start / busy               in_operation, in_packet_handle, in_packet_is_key
// result    out_strobe (one cycle)     out_handle, out_is_key, out_queue_was_empty,
//                                      out_last_of_burst
// config    cfg_valid / cfg_ready      cfg_level_step
//
// A push to a non-full ring, a pointer clear and an empty pop complete without leaving idle, busy low.
// A pop latches the backlog, then emits one burst word per cycle (1 to MAX_LEVEL), each
// result strobed in the cycle after. A push to a full ring jumps the read pointer half
// a ring and reads one RAM entry per walk step up to a keyframe or the write pointer.
// Reset (rst_n low at a clock edge) clears both pointers and marks the ring empty, sets
// level_step to 5 and keeps ring contents. Results cannot be stalled.
`default_nettype none
module keyframe_drop_catchup_queue_core #(
  parameter int QUEUE_DEPTH = kdcq_pkg::QUEUE_DEPTH,
  parameter int MAX_LEVEL   = kdcq_pkg::MAX_LEVEL
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [kdcq_pkg::OP_W-1:0]     in_operation,
  input  wire logic [kdcq_pkg::HANDLE_W-1:0] in_packet_handle,
  input  wire logic                          in_packet_is_key,
  // result channel
  output logic                               out_strobe,
  output logic      [kdcq_pkg::HANDLE_W-1:0] out_handle,
  output logic                               out_is_key,
  output logic                               out_queue_was_empty,
  output logic                               out_last_of_burst,
  // level_step register write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [kdcq_pkg::STEP_W-1:0]   cfg_level_step
);

  kdcq_pkg::cmd_t    cmd;
  kdcq_pkg::status_t st;

  // take register words only between commands
  assign cfg_ready = !busy;

  // controller: decode the command word, sequence the keyframe walk and the burst
  kdcq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .operation(in_operation),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  // datapath: pointers, ring RAM, burst counters and result register
  kdcq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_LEVEL  (MAX_LEVEL)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_level_step     (cfg_level_step),
    .in_packet_handle   (in_packet_handle),
    .in_packet_is_key   (in_packet_is_key),
    .out_strobe         (out_strobe),
    .out_handle         (out_handle),
    .out_is_key         (out_is_key),
    .out_queue_was_empty(out_queue_was_empty),
    .out_last_of_burst  (out_last_of_burst)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/kdcq_ram.sv
`default_nettype none
module kdcq_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/kdcq_ctrl.sv
`default_nettype none
module kdcq_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [kdcq_pkg::OP_W-1:0] operation,
  input  wire kdcq_pkg::status_t         st,
  output kdcq_pkg::cmd_t                 cmd,
  output logic                           busy
);

  kdcq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kdcq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != kdcq_pkg::ST_IDLE);
    unique case (state_r)
      kdcq_pkg::ST_IDLE: begin
        if (start) begin
          unique case (operation)
            kdcq_pkg::OP_PUSH: begin
              if (st.full) begin
                cmd.half_adv = 1'b1;
                state_nxt    = kdcq_pkg::ST_WALK;
              end else begin
                cmd.push_in = 1'b1;
              end
            end
            kdcq_pkg::OP_POP: begin
              if (st.empty) begin
                cmd.pop_empty = 1'b1;
              end else begin
                cmd.pop_start = 1'b1;
                state_nxt     = kdcq_pkg::ST_POP;
              end
            end
            kdcq_pkg::OP_CLEAR: cmd.clear_ptrs = 1'b1;
            default: ;
          endcase
        end
      end
      kdcq_pkg::ST_WALK: begin
        if (st.walk_done) begin
          cmd.push_held = 1'b1;
          state_nxt     = kdcq_pkg::ST_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      kdcq_pkg::ST_POP: begin
        cmd.pop_emit = 1'b1;
        if (!st.burst_more) begin
          state_nxt = kdcq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kdcq_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/kdcq_dp.sv
`default_nettype none
module kdcq_dp #(
  parameter int QUEUE_DEPTH = kdcq_pkg::QUEUE_DEPTH,
  parameter int MAX_LEVEL   = kdcq_pkg::MAX_LEVEL
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire kdcq_pkg::cmd_t                cmd,
  output kdcq_pkg::status_t                  st,
  input  wire logic                          cfg_we,
  input  wire logic [kdcq_pkg::STEP_W-1:0]   cfg_level_step,
  input  wire logic [kdcq_pkg::HANDLE_W-1:0] in_packet_handle,
  input  wire logic                          in_packet_is_key,
  output logic                               out_strobe,
  output logic      [kdcq_pkg::HANDLE_W-1:0] out_handle,
  output logic                               out_is_key,
  output logic                               out_queue_was_empty,
  output logic                               out_last_of_burst
);

  localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = AW + 1;
  localparam int LW  = $clog2(MAX_LEVEL + 1);
  localparam int TW  = kdcq_pkg::STEP_W + LW;
  localparam int MW  = ((CW > TW) ? CW : TW) + 1;
  localparam int DW  = kdcq_pkg::HANDLE_W + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] HALF_C   = CW'(QUEUE_DEPTH / 2);

  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic          empty_r, empty_nxt;
  logic [kdcq_pkg::STEP_W-1:0] level_step_r;

  logic [kdcq_pkg::HANDLE_W-1:0] held_handle_r;
  logic                          held_key_r;
  logic [CW-1:0] backlog_r;
  logic [LW-1:0] taken_r;
  logic [TW-1:0] thresh_r;

  logic [AW-1:0] rd_inc, wr_inc, rd_half;
  logic [CW-1:0] half_sum, backlog_now;
  logic [LW-1:0] taken_nxt;
  logic [TW-1:0] thresh_nxt;
  logic          ptr_eq;

  logic          ram_we;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic                          ostrobe_r, ostrobe_nxt;
  logic [kdcq_pkg::HANDLE_W-1:0] ohandle_r;
  logic                          okey_r, oempty_r, olast_r;

  assign ptr_eq  = (rd_ptr_r == wr_ptr_r);
  assign rd_inc  = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
  assign wr_inc  = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;

  // wrap the half-ring jump for any depth
  assign half_sum = {1'b0, rd_ptr_r} + HALF_C;
  assign rd_half  = (half_sum >= DEPTH_C) ? AW'(half_sum - DEPTH_C) : AW'(half_sum);

  assign backlog_now = ptr_eq ? DEPTH_C :
                       (rd_ptr_r > wr_ptr_r) ? ({1'b0, wr_ptr_r} + DEPTH_C - {1'b0, rd_ptr_r})
                                             : ({1'b0, wr_ptr_r} - {1'b0, rd_ptr_r});

  assign taken_nxt  = taken_r + 1'b1;
  assign thresh_nxt = thresh_r + TW'(level_step_r);

  assign st.full       = ptr_eq && !empty_r;
  assign st.empty      = ptr_eq && empty_r;
  assign st.walk_done  = ptr_eq || ram_rdata[DW-1];
  assign st.burst_more = (MW'(taken_nxt) < MW'(backlog_r)) &&
                         (MW'(taken_nxt) < MW'(MAX_LEVEL)) &&
                         (MW'(backlog_r) >= MW'(thresh_nxt));

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    empty_nxt  = empty_r;
    ram_we     = 1'b0;
    ram_wdata  = {in_packet_is_key, in_packet_handle};
    if (cmd.push_in) begin
      ram_we     = 1'b1;
      wr_ptr_nxt = wr_inc;
      empty_nxt  = 1'b0;
    end
    if (cmd.push_held) begin
      ram_we     = 1'b1;
      ram_wdata  = {held_key_r, held_handle_r};
      wr_ptr_nxt = wr_inc;
      empty_nxt  = 1'b0;
    end
    if (cmd.half_adv) begin
      rd_ptr_nxt = rd_half;
    end
    if (cmd.walk_step || cmd.pop_emit) begin
      rd_ptr_nxt = rd_inc;
    end
    if (cmd.pop_emit && !st.burst_more && (rd_inc == wr_ptr_r)) begin
      empty_nxt = 1'b1;
    end
    if (cmd.clear_ptrs) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      empty_nxt  = 1'b1;
    end
  end

  assign ostrobe_nxt = cmd.pop_emit || cmd.pop_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      empty_r      <= 1'b1;
      level_step_r <= kdcq_pkg::LEVEL_STEP_RESET;
      ostrobe_r    <= 1'b0;
    end else begin
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      empty_r   <= empty_nxt;
      ostrobe_r <= ostrobe_nxt;
      if (cfg_we) begin
        level_step_r <= cfg_level_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.half_adv) begin
      held_handle_r <= in_packet_handle;
      held_key_r    <= in_packet_is_key;
    end
    if (cmd.pop_start) begin
      backlog_r <= backlog_now;
      taken_r   <= '0;
      thresh_r  <= '0;
    end else if (cmd.pop_emit) begin
      taken_r  <= taken_nxt;
      thresh_r <= thresh_nxt;
    end
    if (cmd.pop_empty) begin
      ohandle_r <= '0;
      okey_r    <= 1'b0;
      oempty_r  <= 1'b1;
      olast_r   <= 1'b1;
    end else if (cmd.pop_emit) begin
      ohandle_r <= ram_rdata[kdcq_pkg::HANDLE_W-1:0];
      okey_r    <= ram_rdata[DW-1];
      oempty_r  <= 1'b0;
      olast_r   <= !st.burst_more;
    end
  end

  // read address follows the next read pointer so data matches rd_ptr_r
  kdcq_ram #(
    .WIDTH(DW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr_r),
    .wdata(ram_wdata),
    .raddr(rd_ptr_nxt),
    .rdata(ram_rdata)
  );

  assign out_strobe          = ostrobe_r;
  assign out_handle          = ohandle_r;
  assign out_is_key          = okey_r;
  assign out_queue_was_empty = oempty_r;
  assign out_last_of_burst   = olast_r;

endmodule
`default_nettype wire
